[rtl/tfs_pkg.sv]
// Shared types and constants for the three-level feedback scheduler.
// Used by tfs_pick and the scheduler top; depends on nothing.
`default_nettype none
package tfs_pkg;
  localparam int TASK_COUNT  = 8;
  localparam int BURST_SLOTS = 16;
  localparam int TASK_W      = $clog2(TASK_COUNT);
  localparam int SLOT_W      = $clog2(BURST_SLOTS);
  localparam int ADDR_W      = TASK_W + SLOT_W;
  localparam int ENTRY_W     = 16;

  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic [7:0]  QUANTUM_HIGH_RST = 8'd7;
  localparam logic [7:0]  QUANTUM_MID_RST  = 8'd12;

  localparam logic [1:0] CFG_QUANTUM_HIGH = 2'd0;
  localparam logic [1:0] CFG_QUANTUM_MID  = 2'd1;

  localparam logic [1:0] LVL_ONE   = 2'd1;
  localparam logic [1:0] LVL_TWO   = 2'd2;
  localparam logic [1:0] LVL_THREE = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_UNLOADED = 2'd0,
    MODE_READY    = 2'd1,
    MODE_BLOCKED  = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [TASK_W-1:0] best;
    logic [1:0]        lvl;
  } pick_res_t;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction
endpackage
`default_nettype wire

[rtl/tfs_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module tfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end
endmodule
`default_nettype wire

[rtl/tfs_pick.sv]
// Next-task selector: scans one task per cycle with a shared compare.
// Depends on tfs_pkg.
`default_nettype none
module tfs_pick (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          cand_ready,
  input  wire logic [1:0]                    cand_lvl,
  input  wire logic [15:0]                   cand_stamp,
  output logic      [tfs_pkg::TASK_W-1:0]    idx,
  output tfs_pkg::pick_res_t                 res
);
  logic                       busy_r;
  logic [tfs_pkg::TASK_W-1:0] idx_r;
  logic                       found_r;
  logic [1:0]                 lvl_r;
  logic [15:0]                stamp_r;
  logic [tfs_pkg::TASK_W-1:0] best_r;
  logic                       done_r;
  logic                       better;

  assign better = cand_ready && (!found_r || cand_lvl < lvl_r ||
                  (cand_lvl == lvl_r && cand_stamp < stamp_r));
  assign idx = idx_r;
  assign res = '{done: done_r, found: found_r, best: best_r, lvl: lvl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      found_r <= 1'b0;
      lvl_r   <= '0;
      stamp_r <= '0;
      best_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (busy_r) begin
        if (better) begin
          found_r <= 1'b1;
          lvl_r   <= cand_lvl;
          stamp_r <= cand_stamp;
          best_r  <= idx_r;
        end
        if (idx_r == tfs_pkg::TASK_W'(tfs_pkg::TASK_COUNT - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/three_level_feedback_scheduler.sv]
// Three-level feedback scheduler top: sequencer, task state, burst RAM; uses
// tfs_pkg, tfs_ram and tfs_pick. A load beat goes through ST_FIN to ST_OUT.
// A tick beat may take up to two task scans, and each task leaving I/O (at most
// 8) reloads its burst length through the RAM port.
// One beat in flight; the next is taken the cycle after the result is accepted.
// Synchronous active-low reset clears all task state; the burst RAM is not cleared.
`default_nettype none
module three_level_feedback_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [2:0]  in_task_id,
  input  wire logic [3:0]  in_slot,
  input  wire logic [7:0]  in_burst_ticks,
  input  wire logic [7:0]  in_io_time,
  input  wire logic        in_last_burst,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_running_task,
  output logic             out_cpu_idle,
  output logic             out_finished_valid,
  output logic [2:0]       out_finished_task,
  output logic [15:0]      out_finished_wait,
  output logic [15:0]      out_finished_response,
  output logic [15:0]      out_finished_turnaround,
  output logic             out_all_done,
  output logic [15:0]      out_now_tick,
  output logic [15:0]      out_idle_ticks,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  localparam int TC = tfs_pkg::TASK_COUNT;
  localparam int TW = tfs_pkg::TASK_W;
  localparam int SW = tfs_pkg::SLOT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_SCAN, ST_UPD, ST_FILLRD, ST_FILLWR,
    ST_RUN, ST_DEC, ST_FIN, ST_OUT
  } state_t;

  state_t state_r;

  tfs_pkg::mode_t mode_r  [TC];
  logic [1:0]     lvl_r   [TC];
  logic [SW-1:0]  fslot_r [TC];
  logic [SW-1:0]  cslot_r [TC];
  logic [7:0]     rem_r   [TC];
  logic [15:0]    stamp_r [TC];
  logic [15:0]    wait_r  [TC];
  logic [TC-1:0]  fdflag_r;
  logic [15:0]    fdtick_r [TC];
  logic [TC-1:0]  pend_r;

  logic [7:0]     qhigh_r, qmid_r, qleft_r;
  logic [15:0]    tick_r, idlecnt_r;
  logic [TW-1:0]  cur_r;
  logic [TW-1:0]  fill_idx_r;
  logic           rvalid_r;
  logic           post_r;

  logic [TW-1:0]  sel_idx, pend_idx, pick_idx;
  logic [TC-1:0]  new_pend;
  logic           l1rdy, all_loaded_done, any_loaded;
  logic           in_range, load_beat, ram_wr_en, ram_rd_en;
  logic [tfs_pkg::ENTRY_W-1:0] ram_rd_data;
  logic           pick_start;
  tfs_pkg::pick_res_t pick_res;
  logic           dec_done_burst, dec_last, dec_resched;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign load_beat = in_valid && !in_stall && (in_func == tfs_pkg::FUNC_LOAD);
  assign in_range  = (int'(in_task_id) < TC) && (int'(in_slot) < tfs_pkg::BURST_SLOTS);
  assign ram_wr_en = load_beat && in_range;
  assign ram_rd_en = (state_r == ST_FILLRD) || (state_r == ST_RUN);

  always_comb begin
    pend_idx = '0;
    for (int i = TC - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        pend_idx = TW'(i);
      end
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:   sel_idx = TW'(in_task_id);
      ST_SCAN:   sel_idx = pick_idx;
      ST_FILLRD: sel_idx = pend_idx;
      ST_FILLWR: sel_idx = fill_idx_r;
      default:   sel_idx = cur_r;
    endcase
  end

  always_comb begin
    l1rdy = 1'b0;
    any_loaded = 1'b0;
    all_loaded_done = 1'b1;
    new_pend = '0;
    for (int i = 0; i < TC; i++) begin
      if (mode_r[i] == tfs_pkg::MODE_READY && lvl_r[i] == tfs_pkg::LVL_ONE) begin
        l1rdy = 1'b1;
      end
      if (mode_r[i] != tfs_pkg::MODE_UNLOADED) begin
        any_loaded = 1'b1;
        if (mode_r[i] != tfs_pkg::MODE_FINISHED) begin
          all_loaded_done = 1'b0;
        end
      end
      if (mode_r[i] == tfs_pkg::MODE_BLOCKED && rem_r[i] <= 8'd1) begin
        new_pend[i] = 1'b1;
      end
    end
  end

  assign dec_done_burst = (rem_r[cur_r] == 8'd0);
  assign dec_last = (cslot_r[cur_r] == fslot_r[cur_r]) ||
                    (cslot_r[cur_r] == SW'(tfs_pkg::BURST_SLOTS - 1));
  always_comb begin
    dec_resched = 1'b0;
    if (dec_done_burst) begin
      dec_resched = 1'b1;
    end else if (lvl_r[cur_r] == tfs_pkg::LVL_ONE) begin
      dec_resched = (qleft_r == 8'd0);
    end else if (l1rdy) begin
      dec_resched = 1'b1;
    end else if (lvl_r[cur_r] == tfs_pkg::LVL_TWO && qleft_r == 8'd0) begin
      dec_resched = 1'b1;
    end
  end

  assign pick_start = ((state_r == ST_START) && (mode_r[cur_r] != tfs_pkg::MODE_READY)) ||
                      ((state_r == ST_DEC) && dec_resched);

  tfs_ram #(.WIDTH(tfs_pkg::ENTRY_W), .DEPTH(TC * tfs_pkg::BURST_SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr ({TW'(in_task_id), SW'(in_slot)}),
    .wr_data ({in_burst_ticks, in_io_time}),
    .rd_en   (ram_rd_en),
    .rd_addr ({sel_idx, cslot_r[sel_idx]}),
    .rd_data (ram_rd_data)
  );

  tfs_pick u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (pick_start),
    .cand_ready (mode_r[sel_idx] == tfs_pkg::MODE_READY),
    .cand_lvl   (lvl_r[sel_idx]),
    .cand_stamp (stamp_r[sel_idx]),
    .idx        (pick_idx),
    .res        (pick_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      qhigh_r   <= tfs_pkg::QUANTUM_HIGH_RST;
      qmid_r    <= tfs_pkg::QUANTUM_MID_RST;
      qleft_r   <= tfs_pkg::QUANTUM_HIGH_RST;
      tick_r    <= '0;
      idlecnt_r <= '0;
      cur_r     <= '0;
      fill_idx_r <= '0;
      rvalid_r  <= 1'b0;
      post_r    <= 1'b0;
      pend_r    <= '0;
      fdflag_r  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TC; i++) begin
        mode_r[i]   <= tfs_pkg::MODE_UNLOADED;
        lvl_r[i]    <= tfs_pkg::LVL_ONE;
        fslot_r[i]  <= '0;
        cslot_r[i]  <= '0;
        rem_r[i]    <= '0;
        stamp_r[i]  <= '0;
        wait_r[i]   <= '0;
        fdtick_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tfs_pkg::CFG_QUANTUM_HIGH: qhigh_r <= cfg_data;
          tfs_pkg::CFG_QUANTUM_MID:  qmid_r  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            out_running_task        <= '0;
            out_cpu_idle            <= 1'b0;
            out_finished_valid      <= 1'b0;
            out_finished_task       <= '0;
            out_finished_wait       <= '0;
            out_finished_response   <= '0;
            out_finished_turnaround <= '0;
            if (in_func == tfs_pkg::FUNC_TICK) begin
              state_r <= ST_START;
            end else begin
              if (in_range) begin
                if (in_last_burst) begin
                  fslot_r[sel_idx] <= SW'(in_slot);
                end
                if (in_slot == 4'd0 && mode_r[sel_idx] == tfs_pkg::MODE_UNLOADED) begin
                  mode_r[sel_idx]   <= tfs_pkg::MODE_READY;
                  lvl_r[sel_idx]    <= tfs_pkg::LVL_ONE;
                  cslot_r[sel_idx]  <= '0;
                  rem_r[sel_idx]    <= in_burst_ticks;
                  stamp_r[sel_idx]  <= tick_r;
                  wait_r[sel_idx]   <= '0;
                  fdflag_r[sel_idx] <= 1'b0;
                  fdtick_r[sel_idx] <= '0;
                end
              end
              state_r <= ST_FIN;
            end
          end
        end
        ST_START: begin
          if (mode_r[cur_r] == tfs_pkg::MODE_READY) begin
            rvalid_r <= 1'b1;
            state_r  <= ST_UPD;
          end else begin
            post_r  <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pick_res.done) begin
            if (pick_res.found) begin
              cur_r <= pick_res.best;
              if (pick_res.lvl == tfs_pkg::LVL_ONE) begin
                qleft_r <= qhigh_r;
              end else if (pick_res.lvl == tfs_pkg::LVL_TWO) begin
                qleft_r <= qmid_r;
              end else begin
                qleft_r <= '0;
              end
            end
            if (post_r) begin
              state_r <= ST_FIN;
            end else begin
              rvalid_r <= pick_res.found;
              state_r  <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          tick_r <= tfs_pkg::inc16(tick_r);
          for (int i = 0; i < TC; i++) begin
            if (mode_r[i] == tfs_pkg::MODE_READY && !(rvalid_r && TW'(i) == cur_r)) begin
              wait_r[i] <= tfs_pkg::inc16(wait_r[i]);
            end
            if (mode_r[i] == tfs_pkg::MODE_BLOCKED) begin
              if (new_pend[i]) begin
                mode_r[i]  <= tfs_pkg::MODE_READY;
                stamp_r[i] <= tfs_pkg::inc16(tick_r);
              end else begin
                rem_r[i] <= rem_r[i] - 8'd1;
              end
            end
          end
          pend_r <= new_pend;
          if (!rvalid_r) begin
            out_cpu_idle <= 1'b1;
            idlecnt_r    <= tfs_pkg::inc16(idlecnt_r);
          end else begin
            out_running_task <= 3'(cur_r);
            if (!fdflag_r[cur_r]) begin
              fdflag_r[cur_r] <= 1'b1;
              fdtick_r[cur_r] <= tick_r;
            end
            if (rem_r[cur_r] != 8'd0) begin
              rem_r[cur_r] <= rem_r[cur_r] - 8'd1;
            end
            if (qleft_r != 8'd0) begin
              qleft_r <= qleft_r - 8'd1;
            end
          end
          state_r <= (new_pend != '0) ? ST_FILLRD : ST_RUN;
        end
        ST_FILLRD: begin
          fill_idx_r <= pend_idx;
          state_r    <= ST_FILLWR;
        end
        ST_FILLWR: begin
          rem_r[fill_idx_r]  <= ram_rd_data[15:8];
          pend_r[fill_idx_r] <= 1'b0;
          state_r <= ((pend_r & ~(TC'(1) << fill_idx_r)) != '0) ? ST_FILLRD : ST_RUN;
        end
        ST_RUN: begin
          state_r <= rvalid_r ? ST_DEC : ST_FIN;
        end
        ST_DEC: begin
          if (dec_done_burst) begin
            if (dec_last) begin
              mode_r[cur_r]           <= tfs_pkg::MODE_FINISHED;
              out_finished_valid      <= 1'b1;
              out_finished_task       <= 3'(cur_r);
              out_finished_wait       <= wait_r[cur_r];
              out_finished_response   <= fdtick_r[cur_r];
              out_finished_turnaround <= tick_r;
            end else begin
              mode_r[cur_r]  <= tfs_pkg::MODE_BLOCKED;
              rem_r[cur_r]   <= ram_rd_data[7:0];
              cslot_r[cur_r] <= cslot_r[cur_r] + 1'b1;
            end
          end else if (dec_resched) begin
            stamp_r[cur_r] <= tick_r;
            if (lvl_r[cur_r] == tfs_pkg::LVL_ONE) begin
              lvl_r[cur_r] <= tfs_pkg::LVL_TWO;
            end else if (!l1rdy) begin
              lvl_r[cur_r] <= tfs_pkg::LVL_THREE;
            end
          end
          if (dec_resched) begin
            post_r  <= 1'b1;
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_all_done <= any_loaded && all_loaded_done;
          out_now_tick <= tick_r;
          out_idle_ticks <= idlecnt_r;
          out_valid <= 1'b1;
          state_r   <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the three-level feedback scheduler: drives load and tick beats,
// predicts every result beat in a task-level model, and checks them in order.
// Depends on tfs_pkg and three_level_feedback_scheduler.
`timescale 1ns / 1ps
module tb;
  localparam int NT = 8;
  localparam int NS = 16;

  typedef struct packed {
    logic       func;
    logic [2:0] task_id;
    logic [3:0] slot;
    logic [7:0] burst_ticks;
    logic [7:0] io_time;
    logic       last_burst;
  } sched_beat_t;

  typedef struct packed {
    logic [2:0]  running_task;
    logic        cpu_idle;
    logic        finished_valid;
    logic [2:0]  finished_task;
    logic [15:0] finished_wait;
    logic [15:0] finished_response;
    logic [15:0] finished_turnaround;
    logic        all_done;
    logic [15:0] now_tick;
    logic [15:0] idle_ticks;
  } sched_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [2:0] in_task_id = '0;
  logic [3:0] in_slot = '0;
  logic [7:0] in_burst_ticks = '0;
  logic [7:0] in_io_time = '0;
  logic in_last_burst = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_running_task;
  logic out_cpu_idle;
  logic out_finished_valid;
  logic [2:0] out_finished_task;
  logic [15:0] out_finished_wait;
  logic [15:0] out_finished_response;
  logic [15:0] out_finished_turnaround;
  logic out_all_done;
  logic [15:0] out_now_tick;
  logic [15:0] out_idle_ticks;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  three_level_feedback_scheduler DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler shadow state
  logic [7:0]  m_burst [NT*NS];
  logic [7:0]  m_io [NT*NS];
  logic [3:0]  m_final [NT];
  logic [3:0]  m_slot [NT];
  logic [7:0]  m_remain [NT];
  logic [1:0]  m_level [NT];
  tfs_pkg::mode_t m_mode [NT];
  logic [15:0] m_stamp [NT];
  logic [15:0] m_wait [NT];
  logic [16:0] m_first [NT];
  logic [7:0]  m_qleft;
  logic [15:0] m_tick;
  logic [15:0] m_idle;
  int          m_cur;
  logic [7:0]  m_qhigh;
  logic [7:0]  m_qmid;

  sched_beat_t   pending_beats[$];
  sched_status_t expected_status[$];
  int  errors = 0;
  bit  calm = 1'b0;
  int  hold_off = 0;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic int oldest_ready();
    for (int lvl = 1; lvl <= 3; lvl++) begin
      int best;
      best = -1;
      for (int i = 0; i < NT; i++)
        if (m_mode[i] == tfs_pkg::MODE_READY && m_level[i] == lvl &&
            (best < 0 || m_stamp[i] < m_stamp[best])) best = i;
      if (best >= 0) return best;
    end
    return -1;
  endfunction

  task automatic run_task(int t);
    m_cur = t;
    if (m_level[t] == tfs_pkg::LVL_ONE) m_qleft = m_qhigh;
    else if (m_level[t] == tfs_pkg::LVL_TWO) m_qleft = m_qmid;
    else m_qleft = '0;
  endtask

  task automatic predict_status(sched_beat_t b);
    sched_status_t s;
    int r, a, n, loaded, done;
    bit resched, l1;
    logic [15:0] pre;
    s = '0;
    if (b.func == tfs_pkg::FUNC_LOAD) begin
      a = b.task_id * NS + b.slot;
      m_burst[a] = b.burst_ticks;
      m_io[a] = b.io_time;
      if (b.last_burst) m_final[b.task_id] = b.slot;
      if (b.slot == 0 && m_mode[b.task_id] == tfs_pkg::MODE_UNLOADED) begin
        m_mode[b.task_id] = tfs_pkg::MODE_READY;
        m_level[b.task_id] = tfs_pkg::LVL_ONE;
        m_slot[b.task_id] = '0;
        m_remain[b.task_id] = b.burst_ticks;
        m_stamp[b.task_id] = m_tick;
        m_wait[b.task_id] = '0;
        m_first[b.task_id] = '0;
      end
    end else begin
      pre = m_tick;
      r = -1;
      if (m_mode[m_cur] == tfs_pkg::MODE_READY) r = m_cur;
      else begin
        n = oldest_ready();
        if (n >= 0) begin
          run_task(n);
          r = n;
        end
      end
      m_tick = sat_inc(m_tick);
      for (int i = 0; i < NT; i++)
        if (m_mode[i] == tfs_pkg::MODE_READY && i != r) m_wait[i] = sat_inc(m_wait[i]);
      if (r < 0) begin
        s.cpu_idle = 1'b1;
        m_idle = sat_inc(m_idle);
      end else begin
        s.running_task = 3'(r);
        if (!m_first[r][16]) m_first[r] = {1'b1, pre};
        if (m_remain[r] > 0) m_remain[r]--;
        if (m_qleft > 0) m_qleft--;
      end
      for (int i = 0; i < NT; i++) begin
        if (m_mode[i] != tfs_pkg::MODE_BLOCKED) continue;
        if (m_remain[i] > 0) m_remain[i]--;
        if (m_remain[i] == 0) begin
          m_mode[i] = tfs_pkg::MODE_READY;
          m_stamp[i] = m_tick;
          m_remain[i] = m_burst[i*NS + m_slot[i]];
        end
      end
      if (r >= 0) begin
        resched = 1'b0;
        l1 = 1'b0;
        for (int i = 0; i < NT; i++)
          if (m_mode[i] == tfs_pkg::MODE_READY && m_level[i] == tfs_pkg::LVL_ONE) l1 = 1'b1;
        if (m_remain[r] == 0) begin
          if (m_slot[r] == m_final[r] || m_slot[r] == NS-1) begin
            m_mode[r] = tfs_pkg::MODE_FINISHED;
            s.finished_valid = 1'b1;
            s.finished_task = 3'(r);
            s.finished_wait = m_wait[r];
            s.finished_response = m_first[r][15:0];
            s.finished_turnaround = m_tick;
          end else begin
            m_mode[r] = tfs_pkg::MODE_BLOCKED;
            m_remain[r] = m_io[r*NS + m_slot[r]];
            m_slot[r] = m_slot[r] + 4'd1;
          end
          resched = 1'b1;
        end else if (m_level[r] == tfs_pkg::LVL_ONE) begin
          if (m_qleft == 0) begin
            m_level[r] = tfs_pkg::LVL_TWO;
            m_stamp[r] = m_tick;
            resched = 1'b1;
          end
        end else if (l1) begin
          m_stamp[r] = m_tick;
          resched = 1'b1;
        end else if (m_level[r] == tfs_pkg::LVL_TWO && m_qleft == 0) begin
          m_level[r] = tfs_pkg::LVL_THREE;
          m_stamp[r] = m_tick;
          resched = 1'b1;
        end
        if (resched) begin
          n = oldest_ready();
          if (n >= 0) run_task(n);
        end
      end
    end
    loaded = 0;
    done = 0;
    for (int i = 0; i < NT; i++)
      if (m_mode[i] != tfs_pkg::MODE_UNLOADED) begin
        loaded++;
        if (m_mode[i] == tfs_pkg::MODE_FINISHED) done++;
      end
    s.all_done = (loaded > 0 && loaded == done);
    s.now_tick = m_tick;
    s.idle_ticks = m_idle;
    expected_status.push_back(s);
  endtask

  task automatic reset_shadow();
    for (int i = 0; i < NT; i++) begin
      m_final[i] = '0;
      m_slot[i] = '0;
      m_remain[i] = '0;
      m_level[i] = tfs_pkg::LVL_ONE;
      m_mode[i] = tfs_pkg::MODE_UNLOADED;
      m_stamp[i] = '0;
      m_wait[i] = '0;
      m_first[i] = '0;
    end
    for (int i = 0; i < NT*NS; i++) begin
      m_burst[i] = '0;
      m_io[i] = '0;
    end
    m_qhigh = tfs_pkg::QUANTUM_HIGH_RST;
    m_qmid = tfs_pkg::QUANTUM_MID_RST;
    m_qleft = m_qhigh;
    m_tick = '0;
    m_idle = '0;
    m_cur = 0;
  endtask

  task automatic queue_load(int t, int sl, int cb, int io, bit lst);
    sched_beat_t b;
    b.func = tfs_pkg::FUNC_LOAD;
    b.task_id = 3'(t);
    b.slot = 4'(sl);
    b.burst_ticks = 8'(cb);
    b.io_time = 8'(io);
    b.last_burst = lst;
    pending_beats.push_back(b);
  endtask

  task automatic queue_ticks(int n);
    sched_beat_t b;
    for (int i = 0; i < n; i++) begin
      b = '0;
      b.func = tfs_pkg::FUNC_TICK;
      b.task_id = 3'($urandom_range(7, 0));
      b.slot = 4'($urandom_range(15, 0));
      b.burst_ticks = 8'($urandom_range(255, 0));
      b.io_time = 8'($urandom_range(255, 0));
      b.last_burst = 1'($urandom_range(1, 0));
      pending_beats.push_back(b);
    end
  endtask

  // Every task list is written whole, its last slot marked if asked, before its slot 0 starts it.
  task automatic queue_task(int t, int len, bit marked, int maxb);
    for (int sl = len - 1; sl >= 0; sl--)
      queue_load(t, sl, $urandom_range(maxb, 0), $urandom_range(maxb, 0),
                 marked && sl == len - 1);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tfs_pkg::CFG_QUANTUM_HIGH) m_qhigh = val;
    else m_qmid = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Accepted last rising edge?
  logic in_stall_q = 1'b0;
  always @(posedge clk) in_stall_q <= in_valid ? in_stall : 1'b1;

  // Driver: burst idling, hold payload while stalled.
  int gap = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || !in_stall_q)) begin
      if (pending_beats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(9, 0) == 0) begin
        gap <= $urandom_range(12, 0);
        in_valid <= 1'b0;
      end else begin
        {in_func, in_task_id, in_slot, in_burst_ticks, in_io_time, in_last_burst}
          <= pending_beats[0];
        predict_status(pending_beats.pop_front());
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver stall: long hold-off on request, otherwise random bursts.
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(7, 0) == 0) begin
      stall_left <= $urandom_range(12, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin
    sched_status_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_running_task, out_cpu_idle, out_finished_valid, out_finished_task,
             out_finished_wait, out_finished_response, out_finished_turnaround,
             out_all_done, out_now_tick, out_idle_ticks};
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected beat exp none got %h", $time, got);
        errors++;
      end else begin
        want = expected_status.pop_front();
        if (got.running_task != want.running_task)
          $display("%0t: running_task exp %0d got %0d", $time, want.running_task,
                   got.running_task);
        if (got.cpu_idle != want.cpu_idle)
          $display("%0t: cpu_idle exp %0d got %0d", $time, want.cpu_idle, got.cpu_idle);
        if (got.finished_valid != want.finished_valid)
          $display("%0t: finished_valid exp %0d got %0d", $time, want.finished_valid,
                   got.finished_valid);
        if (got.finished_task != want.finished_task)
          $display("%0t: finished_task exp %0d got %0d", $time, want.finished_task,
                   got.finished_task);
        if (got.finished_wait != want.finished_wait)
          $display("%0t: finished_wait exp %0d got %0d", $time, want.finished_wait,
                   got.finished_wait);
        if (got.finished_response != want.finished_response)
          $display("%0t: finished_response exp %0d got %0d", $time,
                   want.finished_response, got.finished_response);
        if (got.finished_turnaround != want.finished_turnaround)
          $display("%0t: finished_turnaround exp %0d got %0d", $time,
                   want.finished_turnaround, got.finished_turnaround);
        if (got.all_done != want.all_done)
          $display("%0t: all_done exp %0d got %0d", $time, want.all_done, got.all_done);
        if (got.now_tick != want.now_tick)
          $display("%0t: now_tick exp %0d got %0d", $time, want.now_tick, got.now_tick);
        if (got.idle_ticks != want.idle_ticks)
          $display("%0t: idle_ticks exp %0d got %0d", $time, want.idle_ticks,
                   got.idle_ticks);
        if (got != want) errors++;
      end
    end
  end

  // Run several scheduling sessions; reset happens only once, so later
  // sessions load the tasks still unloaded and leave done ones alone.
  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extremes, unmarked list, zero burst and zero I/O, bad slots
    queue_ticks(2);
    queue_load(0, 1, 0, 255, 1);
    queue_load(0, 0, 0, 0, 0);
    queue_load(1, 0, 255, 0, 1);
    queue_load(2, 15, 1, 0, 0);
    for (int sl = 14; sl >= 0; sl--) queue_load(2, sl, 1, 0, 0);
    queue_load(0, 0, 9, 9, 0);
    queue_ticks(3);
    drain();
    write_cfg(tfs_pkg::CFG_QUANTUM_HIGH, 8'd1);
    write_cfg(tfs_pkg::CFG_QUANTUM_MID, 8'd1);
    queue_ticks(30);
    drain();
    write_cfg(tfs_pkg::CFG_QUANTUM_HIGH, 8'd0);
    write_cfg(tfs_pkg::CFG_QUANTUM_MID, 8'd0);
    queue_ticks(220);
    drain();
    write_cfg(tfs_pkg::CFG_QUANTUM_HIGH, 8'd255);
    write_cfg(tfs_pkg::CFG_QUANTUM_MID, 8'd255);
    queue_task(3, 2, 1'b1, 40);
    hold_off = 300;
    queue_ticks(60);
    drain();

    // random: remaining tasks with short bursts, mixed with ticks
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(tfs_pkg::CFG_QUANTUM_HIGH, 8'($urandom_range(8, 1)));
      write_cfg(tfs_pkg::CFG_QUANTUM_MID, 8'($urandom_range(16, 1)));
      if (ph == 3) calm = 1'b1;
      for (int t = 4 + ph; t < 5 + ph && t < NT; t++)
        queue_task(t, $urandom_range(NS, 1), 1'($urandom_range(1, 0)), 6);
      queue_ticks(80);
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
